>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on the rising clock edge, ignored while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Same check, without a reset qualifier.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/core/btlpm_pkg.sv
// Package with trie node layout and sizing constants for the LPM engine.
package btlpm_pkg;

  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned PORT_COUNT = 16;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam int unsigned USED_W     = $clog2(NODE_COUNT + 1);
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned DEPTH_W    = 6;
  localparam int unsigned PORT_W     = 4;
  localparam int unsigned PORT_CMP_W = 9;

  // Request kinds carried on the input tuser bit
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // One trie node as stored in the node memory
  typedef struct packed {
    logic              valid;
    logic [31:0]       hop;
    logic [PORT_W-1:0] port;
    logic [IDX_W-1:0]  child1;
    logic [IDX_W-1:0]  child0;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

endpackage

>>> rtl/core/binary_trie_longest_prefix_match_top.sv
// Binary-trie IPv4 longest-prefix-match engine: route insert and address lookup.
//
// Each request is accepted in ST_IDLE and then walked in ST_WALK, one trie level at a time. The
// single node memory port (at most one read per level, registered read data) paces the walk. A
// lookup visits up to 33 levels (root through depth 32); an insert walks prefix_len + 1 levels at
// most. A full pool ends the insert early. While the output register still holds an unread
// result, the walk waits at its last level until it frees. Nodes are allocated from a bump
// counter; the root is treated as empty until first written, so no clearing pass is needed after
// reset. Requests are handled one at a time; a finished result waits in the output register while
// the next request is accepted and walked.
`include "assert_macros.svh"

module binary_trie_longest_prefix_match_top
  import btlpm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] prefix, [37:32] prefix_len, [69:38] route hop,
  // [73:70] route_port, [105:74] lookup_addr, [111:106] zero
  input  logic [111:0] s_axis_tdata,
  // [0] action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] found, [32:1] hop, [36:33] out_port, [37] table_full, [39:38] zero
  output logic [39:0]  m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  // Request fields
  logic [31:0]       in_prefix;
  logic [5:0]        in_len;
  logic [31:0]       in_hop;
  logic [PORT_W-1:0] in_port;
  logic [31:0]       in_addr;

  assign in_prefix = s_axis_tdata[31:0];
  assign in_len    = s_axis_tdata[37:32];
  assign in_hop    = s_axis_tdata[69:38];
  assign in_port   = s_axis_tdata[73:70];
  assign in_addr   = s_axis_tdata[105:74];

  // Control and working registers
  state_e             state_q, state_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic               root_init_q, root_init_d;
  logic               act_q;
  logic               drop_q;
  logic [31:0]        key_q;
  logic [DEPTH_W-1:0] len_q;
  logic [31:0]        hop_q;
  logic [PORT_W-1:0]  port_q;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               from_mem_q, from_mem_d;
  node_t              cur_q, cur_d;
  logic               best_found_q, best_found_d;
  logic [31:0]        best_hop_q, best_hop_d;
  logic [PORT_W-1:0]  best_port_q, best_port_d;
  logic               out_valid_q, out_valid_d;
  logic [39:0]        out_data_q, out_data_d;

  // Node memory
  node_t            mem_q [NODE_COUNT];
  node_t            rd_q;
  logic             rd_root_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  node_t            wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_root_q <= 1'b0;
    end else if (rd_en) begin
      rd_root_q <= (rd_addr == '0);
    end
  end

  // Current node: fresh memory data (empty for a root not yet written), or a just-allocated empty node
  node_t node_cur;
  always_comb begin
    if (!from_mem_q) begin
      node_cur = cur_q;
    end else if (rd_root_q && !root_init_q) begin
      node_cur = '0;
    end else begin
      node_cur = rd_q;
    end
  end

  // Walk step decode
  logic             s_fire;
  logic             out_free;
  logic [4:0]       bit_pos;
  logic             key_bit;
  logic [IDX_W-1:0] child;
  logic             at_end;
  logic             pool_full;
  logic             port_ok;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign bit_pos   = 5'(ADDR_BITS - 1) - depth_q[4:0];
  assign key_bit   = key_q[bit_pos];
  assign child     = key_bit ? node_cur.child1 : node_cur.child0;
  assign pool_full = (used_q >= USED_W'(NODE_COUNT));
  assign port_ok   = (PORT_CMP_W'(in_port) < PORT_CMP_W'(PORT_COUNT));

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    root_init_d  = root_init_q;
    depth_d      = depth_q;
    idx_d        = idx_q;
    from_mem_d   = from_mem_q;
    cur_d        = cur_q;
    best_found_d = best_found_q;
    best_hop_d   = best_hop_q;
    best_port_d  = best_port_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = node_cur;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          // Start at the root
          rd_en        = 1'b1;
          rd_addr      = '0;
          depth_d      = '0;
          idx_d        = '0;
          from_mem_d   = 1'b1;
          best_found_d = 1'b0;
          best_hop_d   = '0;
          best_port_d  = '0;
          state_d      = ST_WALK;
        end
      end
      ST_WALK: begin
        if (act_q == ACT_LOOKUP) begin
          if (depth_q == DEPTH_W'(ADDR_BITS) || child == '0) begin
            // Deepest route seen so far, including this node
            if (out_free) begin
              out_valid_d = 1'b1;
              if (node_cur.valid) begin
                out_data_d = {3'b000, node_cur.port, node_cur.hop, 1'b1};
              end else begin
                out_data_d = {3'b000, best_port_q, best_hop_q, best_found_q};
              end
              state_d = ST_IDLE;
            end
          end else begin
            if (node_cur.valid) begin
              best_found_d = 1'b1;
              best_hop_d   = node_cur.hop;
              best_port_d  = node_cur.port;
            end
            rd_en      = 1'b1;
            rd_addr    = child;
            idx_d      = child;
            from_mem_d = 1'b1;
            depth_d    = depth_q + 1'b1;
          end
        end else begin
          if (drop_q) begin
            // Port out of range: no change
            if (out_free) begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              state_d     = ST_IDLE;
            end
          end else if (at_end) begin
            // Store the route at this depth
            if (out_free) begin
              wr_en         = 1'b1;
              wr_data.valid = 1'b1;
              wr_data.hop   = hop_q;
              wr_data.port  = port_q;
              out_valid_d   = 1'b1;
              out_data_d    = '0;
              state_d       = ST_IDLE;
            end
          end else if (child != '0) begin
            rd_en      = 1'b1;
            rd_addr    = child;
            idx_d      = child;
            from_mem_d = 1'b1;
            depth_d    = depth_q + 1'b1;
          end else if (pool_full) begin
            // Flush this node (it may be a fresh empty one) and report full
            if (out_free) begin
              wr_en       = 1'b1;
              out_valid_d = 1'b1;
              out_data_d  = {2'b00, 1'b1, 4'b0000, 32'h0000_0000, 1'b0};
              state_d     = ST_IDLE;
            end
          end else begin
            // Allocate a child and link it into the current node
            wr_en = 1'b1;
            if (key_bit) begin
              wr_data.child1 = used_q[IDX_W-1:0];
            end else begin
              wr_data.child0 = used_q[IDX_W-1:0];
            end
            idx_d      = used_q[IDX_W-1:0];
            cur_d      = '0;
            from_mem_d = 1'b0;
            used_d     = used_q + 1'b1;
            depth_d    = depth_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wr_en && wr_addr == '0) begin
      root_init_d = 1'b1;
    end
  end

  assign at_end = (depth_q == len_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= USED_W'(1);
      root_init_q  <= 1'b0;
      depth_q      <= '0;
      from_mem_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      root_init_q  <= root_init_d;
      depth_q      <= depth_d;
      from_mem_q   <= from_mem_d;
      out_valid_q  <= out_valid_d;
      best_found_q <= best_found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cur_q       <= cur_d;
    best_hop_q  <= best_hop_d;
    best_port_q <= best_port_d;
    out_data_q  <= out_data_d;
    if (s_fire) begin
      act_q  <= s_axis_tuser;
      drop_q <= !port_ok;
      key_q  <= (s_axis_tuser == ACT_LOOKUP) ? in_addr : in_prefix;
      len_q  <= (in_len > DEPTH_W'(ADDR_BITS)) ? DEPTH_W'(ADDR_BITS) : in_len;
      hop_q  <= in_hop;
      port_q <= in_port;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `ASSERT_CLK(a_used_range, clk_i, rst_ni,
              used_q >= USED_W'(1) && used_q <= USED_W'(NODE_COUNT))
  `ASSERT_CLK(a_idle_no_write, clk_i, rst_ni, state_q == ST_IDLE |-> !wr_en)
  `ASSERT_CLK(a_one_access, clk_i, rst_ni, !(wr_en && rd_en))
  `ASSERT_CLK(a_depth_range, clk_i, rst_ni, depth_q <= DEPTH_W'(ADDR_BITS))
  `ASSERT_CLK(a_start_walk, clk_i, rst_ni, s_fire |=> state_q == ST_WALK && from_mem_q)

endmodule

>>> verif/tb_binary_trie_longest_prefix_match_top.sv
// Self-checking testbench for the binary-trie longest-prefix-match engine.
`timescale 1ns / 1ps

module tb_binary_trie_longest_prefix_match_top;
  import btlpm_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned CALM_ITEMS  = 100;   // last requests sent without idling
  localparam int unsigned DRAIN_WAIT  = 40;    // longest walk plus margin

  // One request as queued for the driver
  typedef struct {
    logic        act;
    logic [31:0] pfx;
    logic [5:0]  plen;
    logic [31:0] hop;
    logic [3:0]  port;
    logic [31:0] addr;
    bit          drain;  // hold off until every earlier result is back
  } lpm_req_t;

  // Result fields, highest bit first as on m_axis_tdata[37:0]
  typedef struct packed {
    logic        table_full;
    logic [3:0]  port;
    logic [31:0] hop;
    logic        found;
  } lpm_rsp_t;

  typedef struct {
    logic [31:0] pfx;
    logic [5:0]  plen;
  } route_key_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;

  binary_trie_longest_prefix_match_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lpm_req_t    pending_reqs[$];
  lpm_rsp_t    expected_rsps[$];
  route_key_t  route_book[$];
  lpm_req_t    cur_req;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned idle_cycles;
  int unsigned mismatches;
  bit          calm;

  // Shadow trie: node 0 is the root, a child link of 0 means none
  bit          trie_valid[NODE_COUNT];
  logic [31:0] trie_hop[NODE_COUNT];
  logic [3:0]  trie_port[NODE_COUNT];
  int unsigned trie_kid[NODE_COUNT][2];
  int unsigned trie_alloc;

  function automatic void trie_clear();
    for (int n = 0; n < NODE_COUNT; n++) begin
      trie_valid[n]  = 1'b0;
      trie_hop[n]    = '0;
      trie_port[n]   = '0;
      trie_kid[n][0] = 0;
      trie_kid[n][1] = 0;
    end
    trie_alloc = 1;
  endfunction

  // Walk the prefix, allocating nodes; returns 1 when the pool runs dry
  function automatic bit trie_insert(logic [31:0] pfx, logic [5:0] plen_in,
                                     logic [31:0] hop, logic [3:0] port);
    int unsigned plen;
    int unsigned node;
    int unsigned nxt;
    int unsigned b;
    plen = (plen_in > ADDR_BITS) ? ADDR_BITS : plen_in;
    if (port >= PORT_COUNT)
      return 1'b0;
    node = 0;
    for (int d = 0; d < plen; d++) begin
      b   = pfx[ADDR_BITS-1-d];
      nxt = trie_kid[node][b];
      if (nxt == 0) begin
        if (trie_alloc >= NODE_COUNT)
          return 1'b1;
        nxt = trie_alloc;
        trie_alloc++;
        trie_valid[nxt]  = 1'b0;
        trie_hop[nxt]    = '0;
        trie_port[nxt]   = '0;
        trie_kid[nxt][0] = 0;
        trie_kid[nxt][1] = 0;
        trie_kid[node][b] = nxt;
      end
      node = nxt;
    end
    trie_valid[node] = 1'b1;
    trie_hop[node]   = hop;
    trie_port[node]  = port;
    return 1'b0;
  endfunction

  // Deepest valid node along the address path, depth 0 through 32
  function automatic lpm_rsp_t trie_lookup(logic [31:0] addr);
    lpm_rsp_t r;
    int unsigned node;
    r    = '0;
    node = 0;
    for (int d = 0; d <= ADDR_BITS; d++) begin
      if (trie_valid[node]) begin
        r.found = 1'b1;
        r.hop   = trie_hop[node];
        r.port  = trie_port[node];
      end
      if (d == ADDR_BITS)
        break;
      node = trie_kid[node][addr[ADDR_BITS-1-d]];
      if (node == 0)
        break;
    end
    return r;
  endfunction

  function automatic lpm_rsp_t predict_rsp(lpm_req_t q);
    lpm_rsp_t r;
    r = '0;
    if (q.act == ACT_INSERT)
      r.table_full = trie_insert(q.pfx, q.plen, q.hop, q.port);
    else
      r = trie_lookup(q.addr);
    return r;
  endfunction

  function automatic logic [31:0] prefix_mask(logic [5:0] plen);
    int unsigned eff;
    eff = (plen > ADDR_BITS) ? ADDR_BITS : plen;
    return (eff == 0) ? 32'h0 : (32'hFFFF_FFFF << (ADDR_BITS - eff));
  endfunction

  // Request builders; fields the action does not use get random values
  task automatic add_insert(logic [31:0] pfx, logic [5:0] plen,
                            logic [31:0] hop, logic [3:0] port);
    lpm_req_t q;
    route_key_t k;
    q.act  = ACT_INSERT;
    q.pfx  = pfx;
    q.plen = plen;
    q.hop  = hop;
    q.port = port;
    q.addr = $urandom();
    q.drain = 1'b0;
    pending_reqs.push_back(q);
    k.pfx  = pfx;
    k.plen = plen;
    route_book.push_back(k);
  endtask

  task automatic add_lookup(logic [31:0] addr);
    lpm_req_t q;
    q.act  = ACT_LOOKUP;
    q.pfx  = $urandom();
    q.plen = 6'($urandom_range(0, 63));
    q.hop  = $urandom();
    q.port = 4'($urandom());
    q.addr = addr;
    q.drain = 1'b0;
    pending_reqs.push_back(q);
  endtask

  // Fresh prefixes (host routes while filling), overwrites of known routes, or routes near known ones
  task automatic rand_insert(bit filling);
    int unsigned pick;
    int unsigned k;
    logic [31:0] pfx;
    logic [31:0] mask;
    logic [5:0]  plen;
    pick = $urandom_range(0, 99);
    if (filling) begin
      pfx  = $urandom();
      plen = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(32, 63)) : 6'd32;
    end else if (route_book.size() == 0 || pick < 50) begin
      pfx  = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: plen = 6'($urandom_range(24, 32));
        5, 6, 7:       plen = 6'($urandom_range(0, 32));
        default:       plen = 6'($urandom_range(0, 63));
      endcase
    end else begin
      k = $urandom_range(0, route_book.size() - 1);
      if (pick < 70) begin
        pfx  = route_book[k].pfx;
        plen = route_book[k].plen;
      end else begin
        mask = prefix_mask(route_book[k].plen);
        pfx  = (route_book[k].pfx & mask) | ($urandom() & ~mask);
        plen = 6'($urandom_range(0, 40));
      end
    end
    add_insert(pfx, plen, $urandom(), 4'($urandom()));
  endtask

  // Addresses under known routes, near misses, extremes and noise
  task automatic rand_lookup();
    int unsigned pick;
    int unsigned k;
    int unsigned eff;
    logic [31:0] addr;
    logic [31:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      addr = (pick == 0) ? 32'h0 : 32'hFFFF_FFFF;
    end else if (route_book.size() == 0 || pick < 25) begin
      addr = $urandom();
    end else begin
      k    = $urandom_range(0, route_book.size() - 1);
      eff  = (route_book[k].plen > ADDR_BITS) ? ADDR_BITS : route_book[k].plen;
      mask = prefix_mask(route_book[k].plen);
      addr = (route_book[k].pfx & mask) | ($urandom() & ~mask);
      if (pick < 45 && eff > 0)
        addr ^= 32'h1 << (ADDR_BITS - 1 - $urandom_range(0, eff - 1));
    end
    add_lookup(addr);
  endtask

  task automatic rand_phase(int unsigned count, int unsigned insert_pct, bit filling);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < insert_pct)
        rand_insert(filling);
      else
        rand_lookup();
      if ($urandom_range(0, 99) == 0)
        pending_reqs[$].drain = 1'b1;
    end
  endtask

  task automatic note_mismatch(string what, lpm_rsp_t exp_r, lpm_rsp_t act_r);
    if (mismatches < 10)
      $display("%0t %s: expected found=%0b hop=%08h port=%0d full=%0b, got found=%0b hop=%08h port=%0d full=%0b",
               $realtime, what, exp_r.found, exp_r.hop, exp_r.port, exp_r.table_full,
               act_r.found, act_r.hop, act_r.port, act_r.table_full);
    mismatches++;
  endtask

  // Stimulus, reset and end of run
  initial begin
    trie_clear();
    mismatches = 0;
    src_gap    = 0;
    sink_gap   = 0;
    calm       = 1'b0;

    // Empty table, default route, host routes, saturated length, overwrites
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);
    add_insert($urandom(), 6'd0, 32'hC0A8_0001, 4'd1);
    add_lookup($urandom());
    add_insert(32'h0A00_0000, 6'd8, 32'h0A00_00FE, 4'd2);
    add_lookup(32'h0A01_0203);
    add_insert(32'h0A01_0203, 6'd32, 32'hFFFF_FFFF, 4'd15);
    add_lookup(32'h0A01_0203);
    pending_reqs[$].drain = 1'b1;
    add_lookup(32'h0A01_0204);
    add_insert(32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 4'd0);
    add_lookup(32'hFFFF_FFFF);
    add_insert(32'h0000_0000, 6'd40, 32'h1234_5678, 4'd3);
    add_lookup(32'h0000_0000);
    add_lookup(32'h0000_0001);
    add_insert(32'h0A00_0000, 6'd8, 32'h0B0B_0B0B, 4'd4);
    add_lookup(32'h0A09_0909);
    add_insert(32'h8000_0000, 6'd1, 32'h8765_4321, 4'd5);
    add_lookup(32'h8000_0001);
    add_insert(32'h0A01_0200, 6'd24, 32'h5555_AAAA, 4'd6);
    add_lookup(32'h0A01_0203);
    add_lookup(32'h0A01_02C8);
    add_insert(32'h0A01_0203, 6'd32, 32'hAAAA_5555, 4'd9);
    add_lookup(32'h0A01_0203);

    // Mixed traffic, a flood of host routes that runs the pool dry, then more mixed traffic
    rand_phase(400, 45, 1'b0);
    rand_phase(300, 60, 1'b1);
    rand_phase(380, 40, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("binary_trie_longest_prefix_match_top regression: pass");
    end else begin
      $display("binary_trie_longest_prefix_match_top regression: fail");
    end
    $finish;
  end

  // Request driver: predicts each request as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_rsps.push_back(predict_rsp(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        calm = pending_reqs.size() < CALM_ITEMS;
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          // this cycle is the first of an idle gap
          src_gap = $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, cur_req.addr, cur_req.port, cur_req.hop,
                            cur_req.plen, cur_req.pfx};
          s_axis_tuser  <= cur_req.act;
        end
      end
    end
  end

  // Result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor: compare against the oldest prediction
  always @(posedge clk_i) begin
    lpm_rsp_t got;
    lpm_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[37:0];
      if (expected_rsps.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_rsps.pop_front();
        if (got.found !== want.found || got.hop !== want.hop ||
            got.port !== want.port || got.table_full !== want.table_full)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("binary_trie_longest_prefix_match_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/btlpm_pkg.sv
rtl/core/binary_trie_longest_prefix_match_top.sv
verif/tb_binary_trie_longest_prefix_match_top.sv
